/* hdl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int NUM_LEVELS = 4;
    localparam int LVL_W      = 2;
    localparam int PRIO_W     = 3;
    localparam int ID_W       = 16;
    localparam int PAY_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int PEND_W     = 7;
    localparam int ENTRY_W    = ID_W + PAY_W;

    localparam logic [PEND_W-1:0] PEND_MAX = 7'd127;
    localparam logic [ID_W-1:0]   ID_FIRST = 16'd1;

    typedef enum logic {
        KIND_ADD  = 1'b0,
        KIND_TAKE = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic [PRIO_W-1:0] PRIO_NONE     = 3'd0;
    localparam logic [PRIO_W-1:0] PRIO_LOW      = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_CRITICAL = 3'd4;

    typedef struct packed {
        logic capture;
        logic issue_take;
        logic load_direct;
        logic load_take;
    } t_cmd;

    typedef struct packed {
        logic is_take;
        logic empty;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

/* hdl/spq_if.sv */
`default_nettype none

interface spq_req_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [spq_pkg::PRIO_W-1:0]     priority_req;
    logic [spq_pkg::PAY_W-1:0]      payload;

    modport source (output valid, output kind, output priority_req, output payload,
                    input ready);
    modport sink (input valid, input kind, input priority_req, input payload,
                  output ready);
endinterface

interface spq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [spq_pkg::STATUS_W-1:0]   status;
    logic [spq_pkg::ID_W-1:0]       task_id;
    logic [spq_pkg::PRIO_W-1:0]     priority_out;
    logic [spq_pkg::PAY_W-1:0]      payload_out;
    logic [spq_pkg::PEND_W-1:0]     pending_count;
    logic                           is_empty;

    modport source (output valid, output status, output task_id, output priority_out,
                    output payload_out, output pending_count, output is_empty,
                    input ready);
    modport sink (input valid, input status, input task_id, input priority_out,
                  input payload_out, input pending_count, input is_empty,
                  output ready);
endinterface

`default_nettype wire

/* hdl/spq_ram.sv */
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/spq_ctrl.sv */
`default_nettype none

module spq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_take && !i_stat.empty) begin
                    o_cmd.issue_take = 1'b1;
                    n_state          = S_READ;
                end else if (!i_stat.out_busy) begin
                    o_cmd.load_direct = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_READ: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_take = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

/* hdl/spq_dp.sv */
`default_nettype none

module spq_dp #(
    parameter int LEVEL_DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire spq_pkg::t_cmd  i_cmd,
    output spq_pkg::t_stat      o_stat,
    spq_req_if.sink             i_req,
    spq_rsp_if.source           o_rsp
);

    localparam int SLOTS = spq_pkg::NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int SW    = ((HW > CW) ? HW : CW) + 1;
    localparam int TW    = $clog2(SLOTS + 1);
    localparam int PW    = (TW > spq_pkg::PEND_W) ? TW : spq_pkg::PEND_W;

    logic                          r_kind;
    logic [spq_pkg::LVL_W-1:0]     r_add_lvl;
    logic [spq_pkg::PAY_W-1:0]     r_pay;
    logic [HW-1:0]                 r_head [spq_pkg::NUM_LEVELS];
    logic [CW-1:0]                 r_cnt  [spq_pkg::NUM_LEVELS];
    logic [TW-1:0]                 r_total;
    logic [spq_pkg::ID_W-1:0]      r_next_id;
    logic [spq_pkg::PRIO_W-1:0]    r_take_prio;

    logic                          r_o_valid;
    logic [spq_pkg::STATUS_W-1:0]  r_o_status;
    logic [spq_pkg::ID_W-1:0]      r_o_id;
    logic [spq_pkg::PRIO_W-1:0]    r_o_prio;
    logic [spq_pkg::PAY_W-1:0]     r_o_pay;
    logic [spq_pkg::PEND_W-1:0]    r_o_pend;
    logic                          r_o_empty;

    logic [spq_pkg::LVL_W-1:0]     take_lvl;
    logic                          any_pending;
    logic [spq_pkg::LVL_W-1:0]     lvl;
    logic [CW-1:0]                 cnt_sel;
    logic [HW-1:0]                 head_sel;
    logic                          lvl_full;
    logic [SW-1:0]                 tail_sum;
    logic [HW-1:0]                 tail_slot;
    logic [HW-1:0]                 head_next;
    logic [AW-1:0]                 base_addr;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic                          ram_we;
    logic [spq_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [TW-1:0]                 tot_sel;
    logic [PW-1:0]                 tot_wide;
    logic [spq_pkg::PEND_W-1:0]    pend_sat;
    logic [spq_pkg::LVL_W-1:0]     cap_lvl;

    always_comb begin
        priority if (i_req.priority_req >= spq_pkg::PRIO_CRITICAL) begin
            cap_lvl = spq_pkg::LVL_W'(spq_pkg::NUM_LEVELS - 1);
        end else if (i_req.priority_req == spq_pkg::PRIO_NONE) begin
            cap_lvl = '0;
        end else begin
            cap_lvl = spq_pkg::LVL_W'(i_req.priority_req - spq_pkg::PRIO_LOW);
        end
    end

    always_comb begin
        any_pending = 1'b1;
        priority if (r_cnt[3] != '0) begin
            take_lvl = 2'd3;
        end else if (r_cnt[2] != '0) begin
            take_lvl = 2'd2;
        end else if (r_cnt[1] != '0) begin
            take_lvl = 2'd1;
        end else begin
            take_lvl    = 2'd0;
            any_pending = (r_cnt[0] != '0);
        end
    end

    assign lvl      = (r_kind == spq_pkg::KIND_TAKE) ? take_lvl : r_add_lvl;
    assign cnt_sel  = r_cnt[lvl];
    assign head_sel = r_head[lvl];
    assign lvl_full = (cnt_sel == CW'(LEVEL_DEPTH));

    always_comb begin
        tail_sum = SW'(head_sel) + SW'(cnt_sel);
        if (tail_sum >= SW'(LEVEL_DEPTH)) begin
            tail_sum = tail_sum - SW'(LEVEL_DEPTH);
        end
        tail_slot = tail_sum[HW-1:0];
        if (SW'(head_sel) == SW'(LEVEL_DEPTH - 1)) begin
            head_next = '0;
        end else begin
            head_next = head_sel + HW'(1);
        end
    end

    assign base_addr = AW'(lvl) * AW'(LEVEL_DEPTH);
    assign wr_addr   = base_addr + AW'(tail_slot);
    assign rd_addr   = base_addr + AW'(head_sel);
    assign ram_we    = i_cmd.load_direct && (r_kind == spq_pkg::KIND_ADD) && !lvl_full;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata ({r_next_id, r_pay}),
        .i_re    (i_cmd.issue_take),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign tot_sel  = ram_we ? (r_total + TW'(1)) : r_total;
    assign tot_wide = PW'(tot_sel);
    assign pend_sat = (tot_wide > PW'(spq_pkg::PEND_MAX)) ? spq_pkg::PEND_MAX
                                                          : tot_wide[spq_pkg::PEND_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_req.kind;
            r_add_lvl <= cap_lvl;
            r_pay     <= i_req.payload;
        end
        if (i_cmd.issue_take) begin
            r_take_prio <= spq_pkg::PRIO_W'(lvl) + spq_pkg::PRIO_LOW;
        end
        if (i_cmd.load_direct) begin
            r_o_prio <= spq_pkg::PRIO_NONE;
            r_o_pay  <= '0;
            if (r_kind == spq_pkg::KIND_TAKE) begin
                r_o_status <= spq_pkg::ST_EMPTY;
                r_o_id     <= '0;
                r_o_pend   <= '0;
                r_o_empty  <= 1'b1;
            end else if (lvl_full) begin
                r_o_status <= spq_pkg::ST_FULL;
                r_o_id     <= '0;
                r_o_pend   <= pend_sat;
                r_o_empty  <= (r_total == '0);
            end else begin
                r_o_status <= spq_pkg::ST_OK;
                r_o_id     <= r_next_id;
                r_o_pend   <= pend_sat;
                r_o_empty  <= 1'b0;
            end
        end
        if (i_cmd.load_take) begin
            r_o_status <= spq_pkg::ST_OK;
            r_o_id     <= ram_rdata[spq_pkg::ENTRY_W-1:spq_pkg::PAY_W];
            r_o_prio   <= r_take_prio;
            r_o_pay    <= ram_rdata[spq_pkg::PAY_W-1:0];
            r_o_pend   <= pend_sat;
            r_o_empty  <= (r_total == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_total   <= '0;
            r_next_id <= spq_pkg::ID_FIRST;
            r_o_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_cnt[lvl] <= cnt_sel + CW'(1);
                r_total    <= r_total + TW'(1);
                r_next_id  <= r_next_id + spq_pkg::ID_W'(1);
            end
            if (i_cmd.issue_take) begin
                r_head[lvl] <= head_next;
                r_cnt[lvl]  <= cnt_sel - CW'(1);
                r_total     <= r_total - TW'(1);
            end
            if (i_cmd.load_direct || i_cmd.load_take) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_take  = (r_kind == spq_pkg::KIND_TAKE);
    assign o_stat.empty    = !any_pending;
    assign o_stat.out_busy = r_o_valid && !o_rsp.ready;

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.task_id       = r_o_id;
    assign o_rsp.priority_out  = r_o_prio;
    assign o_rsp.payload_out   = r_o_pay;
    assign o_rsp.pending_count = r_o_pend;
    assign o_rsp.is_empty      = r_o_empty;

endmodule

`default_nettype wire

/* hdl/strict_priority_task_queue_unit.sv */
// Strict priority task queue with four levels and first-in first-out order inside a level.
// The request channel i_req carries kind, priority_req and payload; an add stores the
// task in its level and returns a fresh id unless it is full, a take returns the
// highest non-empty level. The response channel o_rsp carries one result per request
// with status, task id, priority, payload, pending count and an empty flag.
// One request is in flight at a time. A request is captured in the idle state. An add
// or a failed take loads its result in the execute state; a successful take reads the
// task store there and loads its result in the read state, because the task store is
// a single memory with a registered read port. The next request is taken back in idle.
// The result sits in an output register; a new request is accepted while it waits,
// and the block stalls only when a second result would overwrite an untaken one.
// Reset clears all level pointers and counts and sets the id counter to one; the
// task store needs no clearing, as an entry is only read after it was written.

`default_nettype none

module strict_priority_task_queue_unit #(
    parameter int LEVEL_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    spq_pkg::t_cmd  cmd;
    spq_pkg::t_stat stat;
    logic           req_ready;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spq_dp #(
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    assign i_req.ready = req_ready;

endmodule

`default_nettype wire
